// ===== rtl/sem_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_pkg
// Shared constants and types of the sobel edge magnitude block.
// ----------------------------------------------------------------------------
package sem_pkg;

    localparam int PIX_W      = 8;
    localparam int GRAD_W     = 11;
    localparam int SQ_W       = 22;
    localparam int ROOT_W     = SQ_W / 2;
    localparam int MAG_W      = ROOT_W + 1;
    localparam int PIX_MAX    = 255;

    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 13;
    localparam int CFG_DATA_W   = 13;
    localparam int CFG_IDX_W    = 8;
    localparam int DIM_MIN      = 3;

    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 8'd1;

    typedef struct packed {
        logic busy;
        logic done;
    } t_sqrt_status;

endpackage

// ===== rtl/sem_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_ram
// Generic single-clock ram, one write port and one read port, registered read.
// ----------------------------------------------------------------------------
module sem_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2048
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/sem_isqrt.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sem_isqrt
// Iterative integer square root, two operand bits per cycle, ceiling result.
// ----------------------------------------------------------------------------
module sem_isqrt (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [sem_pkg::SQ_W-1:0]  i_operand,
    output sem_pkg::t_sqrt_status     o_status,
    output logic [sem_pkg::MAG_W-1:0] o_root_ceil
);

    localparam int REM_W = sem_pkg::ROOT_W + 3;
    localparam int CNT_W = $clog2(sem_pkg::ROOT_W);

    logic                        r_busy;
    logic                        r_done;
    logic [CNT_W-1:0]            r_cnt;
    logic [sem_pkg::SQ_W-1:0]    r_opd;
    logic [REM_W-1:0]            r_rem;
    logic [sem_pkg::ROOT_W-1:0]  r_root;

    logic [REM_W-1:0] n_rem_sh;
    logic [REM_W-1:0] n_trial;
    logic             n_ge;

    always_comb begin
        n_rem_sh = {r_rem[REM_W-3:0], r_opd[sem_pkg::SQ_W-1 -: 2]};
        n_trial  = {1'b0, r_root, 2'b01};
        n_ge     = (n_rem_sh >= n_trial);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(sem_pkg::ROOT_W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_opd  <= i_operand;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_rem  <= n_ge ? (n_rem_sh - n_trial) : n_rem_sh;
            r_root <= {r_root[sem_pkg::ROOT_W-2:0], n_ge};
            r_opd  <= {r_opd[sem_pkg::SQ_W-3:0], 2'b00};
        end
    end

    // nonzero remainder means the floor root falls short of the ceiling
    assign o_root_ceil   = {1'b0, r_root} + sem_pkg::MAG_W'(r_rem != '0);
    assign o_status.busy = r_busy;
    assign o_status.done = r_done;

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> r_busy && !r_done)
        else $error("square root did not start");

    a_last_step_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy && !i_start && r_cnt == '0 |=> r_done && !r_busy)
        else $error("square root did not finish after last step");

    a_not_both: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_done))
        else $error("square root busy and done together");

endmodule

// ===== rtl/sobel_edge_magnitude_3x3.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_3x3
// Streaming 3x3 sobel edge magnitude over raster-order grayscale pixels.
// ----------------------------------------------------------------------------
// One pixel is taken at a time. The two rows above the current pixel live in
// one ram, each entry packing the row above and the row above that; a pixel
// reads its column entry, then writes it back shifted by one row. A border
// pixel gives no result. An interior pixel goes through read, gradient,
// squares, then the 11-step square root loop, which sets the rate. A finished
// result sits in an output register, so the next pixel is taken while it
// waits. Writing either size register restarts the frame at row 0, column 0;
// the line rows are kept. Sizes below 3 act as 3 and sizes above MAX_WIDTH or
// MAX_HEIGHT act as that maximum.
module sobel_edge_magnitude_3x3 #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 4096
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // pixel input
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic [sem_pkg::PIX_W-1:0]        i_gray_pixel,
    // result output
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [sem_pkg::PIX_W-1:0]        o_edge_value,
    output logic                             o_frame_last,
    // register writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [sem_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [sem_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int WID_W = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W = $clog2(MAX_HEIGHT);
    localparam int HGT_W = $clog2(MAX_HEIGHT + 1);
    localparam int ENT_W = 2 * sem_pkg::PIX_W;
    localparam int SUM_W = sem_pkg::PIX_W + 2;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_READ   = 5'b00010,
        ST_SQUARE = 5'b00100,
        ST_START  = 5'b01000,
        ST_ROOT   = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic [sem_pkg::WIDTH_REG_W-1:0]  r_width;
    logic [sem_pkg::HEIGHT_REG_W-1:0] r_height;
    logic [COL_W-1:0]                 r_col;
    logic [ROW_W-1:0]                 r_row;
    logic [COL_W-1:0]                 r_cur_col;
    logic [ROW_W-1:0]                 r_cur_row;
    logic [sem_pkg::PIX_W-1:0]        r_pix;
    logic [sem_pkg::PIX_W-1:0]        r_win [6];
    logic signed [sem_pkg::GRAD_W-1:0] r_gx, r_gy;
    logic [sem_pkg::SQ_W-1:0]         r_gx2, r_gy2;
    logic                             r_last;
    logic                             r_out_valid;
    logic [sem_pkg::PIX_W-1:0]        r_edge;
    logic                             r_frame_last;

    logic [WID_W-1:0] w_eff;
    logic [HGT_W-1:0] h_eff;
    logic             in_accept;
    logic             cfg_write;
    logic             col_wrap;
    logic             row_wrap;

    logic [ENT_W-1:0]          ram_rdata;
    logic [sem_pkg::PIX_W-1:0] t0, t1;
    logic [SUM_W-1:0]          sx_r, sx_l, sy_b, sy_t;
    logic signed [sem_pkg::GRAD_W-1:0] n_gx, n_gy;
    logic signed [sem_pkg::SQ_W-1:0]   gx_ext, gy_ext;
    logic                      interior;
    logic                      n_last;

    sem_pkg::t_sqrt_status     sq_status;
    logic                      sq_start;
    logic [sem_pkg::SQ_W-1:0]  sq_operand;
    logic [sem_pkg::MAG_W-1:0] sq_root;
    logic [sem_pkg::PIX_W-1:0] n_edge;
    logic                      out_free;
    logic                      out_load;

    // effective frame size
    always_comb begin
        if (r_width < sem_pkg::WIDTH_REG_W'(sem_pkg::DIM_MIN)) begin
            w_eff = WID_W'(sem_pkg::DIM_MIN);
        end else if (32'(r_width) > MAX_WIDTH) begin
            w_eff = WID_W'(MAX_WIDTH);
        end else begin
            w_eff = WID_W'(r_width);
        end
        if (r_height < sem_pkg::HEIGHT_REG_W'(sem_pkg::DIM_MIN)) begin
            h_eff = HGT_W'(sem_pkg::DIM_MIN);
        end else if (32'(r_height) > MAX_HEIGHT) begin
            h_eff = HGT_W'(MAX_HEIGHT);
        end else begin
            h_eff = HGT_W'(r_height);
        end
    end

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready &&
                         (i_cfg_index == sem_pkg::REG_IMAGE_WIDTH ||
                          i_cfg_index == sem_pkg::REG_IMAGE_HEIGHT);
    assign in_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != ST_IDLE);

    assign col_wrap = (WID_W'(r_col) + 1'b1 >= w_eff);
    assign row_wrap = (HGT_W'(r_row) + 1'b1 >= h_eff);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= sem_pkg::WIDTH_REG_W'(640);
            r_height <= sem_pkg::HEIGHT_REG_W'(480);
            r_col    <= '0;
            r_row    <= '0;
        end else if (cfg_write) begin
            if (i_cfg_index == sem_pkg::REG_IMAGE_WIDTH) begin
                r_width <= i_cfg_data[sem_pkg::WIDTH_REG_W-1:0];
            end else begin
                r_height <= i_cfg_data[sem_pkg::HEIGHT_REG_W-1:0];
            end
            r_col <= '0;
            r_row <= '0;
        end else if (in_accept) begin
            if (col_wrap) begin
                r_col <= '0;
                r_row <= row_wrap ? '0 : r_row + 1'b1;
            end else begin
                r_col <= r_col + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_cur_col <= r_col;
            r_cur_row <= r_row;
            r_pix     <= i_gray_pixel;
        end
    end

    // entry packs {row above, row above that} for one column
    sem_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == ST_READ),
        .i_waddr (r_cur_col),
        .i_wdata ({r_pix, t1}),
        .i_re    (in_accept),
        .i_raddr (r_col),
        .o_rdata (ram_rdata)
    );

    assign t1 = ram_rdata[ENT_W-1 -: sem_pkg::PIX_W];
    assign t0 = ram_rdata[sem_pkg::PIX_W-1:0];

    // window: [0..2] left column, [3..5] middle column, top to bottom
    always_comb begin
        sx_r = SUM_W'(t0) + {1'b0, t1, 1'b0} + SUM_W'(r_pix);
        sx_l = SUM_W'(r_win[0]) + {1'b0, r_win[1], 1'b0} + SUM_W'(r_win[2]);
        sy_b = SUM_W'(r_win[2]) + {1'b0, r_win[5], 1'b0} + SUM_W'(r_pix);
        sy_t = SUM_W'(r_win[0]) + {1'b0, r_win[3], 1'b0} + SUM_W'(t0);
        n_gx = $signed({1'b0, sx_r}) - $signed({1'b0, sx_l});
        n_gy = $signed({1'b0, sy_b}) - $signed({1'b0, sy_t});
        interior = (r_cur_row >= ROW_W'(2)) && (r_cur_col >= COL_W'(2));
        n_last   = (HGT_W'(r_cur_row) == h_eff - 1'b1) &&
                   (WID_W'(r_cur_col) == w_eff - 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else if (r_state == ST_READ) begin
            r_win[0] <= r_win[3];
            r_win[1] <= r_win[4];
            r_win[2] <= r_win[5];
            r_win[3] <= t0;
            r_win[4] <= t1;
            r_win[5] <= r_pix;
        end
    end

    assign gx_ext = sem_pkg::SQ_W'(r_gx);
    assign gy_ext = sem_pkg::SQ_W'(r_gy);

    always_ff @(posedge i_clk) begin
        if (r_state == ST_READ) begin
            r_gx   <= n_gx;
            r_gy   <= n_gy;
            r_last <= n_last;
        end
        if (r_state == ST_SQUARE) begin
            r_gx2 <= $unsigned(gx_ext * gx_ext);
            r_gy2 <= $unsigned(gy_ext * gy_ext);
        end
    end

    assign sq_start   = (r_state == ST_START);
    assign sq_operand = r_gx2 + r_gy2;

    sem_isqrt u_isqrt (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (sq_start),
        .i_operand   (sq_operand),
        .o_status    (sq_status),
        .o_root_ceil (sq_root)
    );

    assign n_edge = (sq_root >= sem_pkg::MAG_W'(sem_pkg::PIX_MAX)) ? '0 :
                    sem_pkg::PIX_W'(sem_pkg::MAG_W'(sem_pkg::PIX_MAX) - sq_root);

    assign out_free = !r_out_valid || !i_out_stall;
    assign out_load = (r_state == ST_ROOT) && sq_status.done && out_free;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) n_state = ST_READ;
            end
            ST_READ: begin
                n_state = interior ? ST_SQUARE : ST_IDLE;
            end
            ST_SQUARE: begin
                n_state = ST_START;
            end
            ST_START: begin
                n_state = ST_ROOT;
            end
            ST_ROOT: begin
                if (out_load) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_edge       <= n_edge;
            r_frame_last <= r_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_edge_value = r_edge;
    assign o_frame_last = r_frame_last;

    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> r_state == ST_READ)
        else $error("accepted beat did not move to read");

    a_col_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        WID_W'(r_col) < w_eff && HGT_W'(r_row) < h_eff)
        else $error("position outside frame");

    a_root_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_ROOT |-> sq_status.busy || sq_status.done)
        else $error("waiting on idle square root");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> r_out_valid)
        else $error("result lost on load");

endmodule

// ===== tb/tb_sobel_edge_magnitude_3x3.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sobel_edge_magnitude_3x3
// Self-checking bench for the streaming 3x3 sobel edge magnitude block.
// ----------------------------------------------------------------------------
// Pixels are streamed in bursts from a queue while the result side stalls on
// changing patterns, including one long hold-off that backs up the input.
// Each accepted pixel runs through a local model of the line rows, window and
// raster counters, and each expected edge value is checked against the output
// in order. Frame sizes are set between phases: directed small frames with
// the size clamps, the ignored register index and a mid-frame restart, then
// random small frames, and one widest and one tallest frame setting.
module tb_sobel_edge_magnitude_3x3;

    localparam int MAX_WIDTH      = 2048;
    localparam int MAX_HEIGHT     = 4096;
    localparam int CYCLE_LIMIT    = 1000000;
    localparam int DRAIN_LIMIT    = 3000;
    localparam int SETTLE_CYCLES  = 40;
    localparam int RANDOM_PIXELS  = 250;
    localparam int PRESSURE_PIXELS = 54;
    localparam int LONG_HOLD      = 400;

    localparam logic [sem_pkg::CFG_IDX_W-1:0] BAD_REG_INDEX = 8'hFF;

    typedef struct {
        logic [sem_pkg::PIX_W-1:0] edge_value;
        logic                      frame_last;
    } t_edge_result;

    typedef enum int {PIX_NOISE, PIX_EXTREME, PIX_SMOOTH} t_pix_style;
    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_PERIODIC} t_rx_mode;

    logic                            i_clk        = 1'b0;
    logic                            i_rst_n      = 1'b0;
    logic                            i_in_valid   = 1'b0;
    logic                            o_in_stall;
    logic [sem_pkg::PIX_W-1:0]       i_gray_pixel = '0;
    logic                            o_out_valid;
    logic                            i_out_stall  = 1'b0;
    logic [sem_pkg::PIX_W-1:0]       o_edge_value;
    logic                            o_frame_last;
    logic                            i_cfg_valid  = 1'b0;
    logic                            o_cfg_ready;
    logic [sem_pkg::CFG_IDX_W-1:0]   i_cfg_index  = '0;
    logic [sem_pkg::CFG_DATA_W-1:0]  i_cfg_data   = '0;

    sobel_edge_magnitude_3x3 #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_gray_pixel (i_gray_pixel),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_edge_value (o_edge_value),
        .o_frame_last (o_frame_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // local copy of the block state
    logic [sem_pkg::PIX_W-1:0]        row_above_mem  [0:MAX_WIDTH-1];
    logic [sem_pkg::PIX_W-1:0]        row_above2_mem [0:MAX_WIDTH-1];
    logic [sem_pkg::PIX_W-1:0]        window_q [0:5];
    int unsigned                      next_col;
    int unsigned                      next_row;
    logic [sem_pkg::WIDTH_REG_W-1:0]  width_reg;
    logic [sem_pkg::HEIGHT_REG_W-1:0] height_reg;

    t_edge_result               edge_expect_q[$];
    logic [sem_pkg::PIX_W-1:0]  pixel_queue[$];

    int pixels_pushed   = 0;
    int pixels_accepted = 0;
    int results_seen    = 0;
    int frame_ends      = 0;
    int cfg_writes      = 0;
    int fail_count      = 0;
    int cycle_count     = 0;
    int smooth_base     = 128;

    int       burst_left      = 0;
    int       gap_left        = 0;
    t_rx_mode rx_mode         = RX_FREE;
    int       rx_mode_left    = 0;
    int       rx_tick         = 0;
    int       hold_off_left   = 0;
    logic     long_hold_done  = 1'b0;

    function automatic int unsigned effective_size(input int unsigned v,
                                                   input int unsigned maxv);
        if (v < sem_pkg::DIM_MIN) return sem_pkg::DIM_MIN;
        if (v > maxv) return maxv;
        return v;
    endfunction

    // smallest r with r*r >= n
    function automatic int unsigned root_ceiling(input int unsigned n);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lo = 0;
        hi = 2048;
        while (lo < hi) begin
            mid = (lo + hi) / 2;
            if (mid * mid >= n) hi = mid;
            else lo = mid + 1;
        end
        return lo;
    endfunction

    task automatic predict_edge(input logic [sem_pkg::PIX_W-1:0] pix);
        int unsigned  w;
        int unsigned  h;
        int unsigned  c;
        int unsigned  r;
        int unsigned  mag;
        int           top;
        int           mid;
        int           bot;
        int           gx;
        int           gy;
        t_edge_result res;
        w = effective_size(32'(width_reg), MAX_WIDTH);
        h = effective_size(32'(height_reg), MAX_HEIGHT);
        c = next_col;
        r = next_row;
        if (c >= w) c = w - 1;
        if (r >= h) r = h - 1;
        top = int'(row_above2_mem[c]);
        mid = int'(row_above_mem[c]);
        bot = int'(pix);
        row_above2_mem[c] = row_above_mem[c];
        row_above_mem[c]  = pix;
        if (r >= 2 && c >= 2) begin
            gx = (top + 2 * mid + bot) -
                 (int'(window_q[0]) + 2 * int'(window_q[1]) + int'(window_q[2]));
            gy = (int'(window_q[2]) + 2 * int'(window_q[5]) + bot) -
                 (int'(window_q[0]) + 2 * int'(window_q[3]) + top);
            mag = root_ceiling(unsigned'(gx * gx + gy * gy));
            if (mag >= sem_pkg::PIX_MAX) res.edge_value = '0;
            else res.edge_value = sem_pkg::PIX_W'(sem_pkg::PIX_MAX - mag);
            res.frame_last = (r == h - 1) && (c == w - 1);
            if (res.frame_last) frame_ends++;
            edge_expect_q.push_back(res);
        end
        window_q[0] = window_q[3];
        window_q[1] = window_q[4];
        window_q[2] = window_q[5];
        window_q[3] = top[sem_pkg::PIX_W-1:0];
        window_q[4] = mid[sem_pkg::PIX_W-1:0];
        window_q[5] = pix;
        c++;
        if (c >= w) begin
            c = 0;
            r++;
            if (r >= h) r = 0;
        end
        next_col = c;
        next_row = r;
    endtask

    task automatic check_edge_result(input logic [sem_pkg::PIX_W-1:0] edge_value,
                                     input logic frame_last);
        t_edge_result want;
        if (edge_expect_q.size() == 0) begin
            fail_count++;
            $error("unexpected result: edge_value %0d frame_last %0d", edge_value, frame_last);
        end else begin
            want = edge_expect_q.pop_front();
            if (edge_value !== want.edge_value) begin
                fail_count++;
                $error("edge_value mismatch: expected %0d, actual %0d",
                       want.edge_value, edge_value);
            end
            if (frame_last !== want.frame_last) begin
                fail_count++;
                $error("frame_last mismatch: expected %0d, actual %0d",
                       want.frame_last, frame_last);
            end
        end
    endtask

    // pixel driver: bursts with random gaps, payload held while stalled
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall) begin
                predict_edge(i_gray_pixel);
                pixels_accepted <= pixels_accepted + 1;
            end
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left != 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (pixel_queue.size() != 0) begin
                    i_in_valid   <= 1'b1;
                    i_gray_pixel <= pixel_queue.pop_front();
                    if (burst_left != 0) begin
                        burst_left--;
                    end else if ($urandom_range(0, 3) == 0) begin
                        burst_left = $urandom_range(40, 160);
                        gap_left   = 0;
                    end else begin
                        burst_left = $urandom_range(0, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // result monitor with its own stall pattern
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                check_edge_result(o_edge_value, o_frame_last);
                results_seen <= results_seen + 1;
            end
            if (rx_mode_left == 0) begin
                rx_mode      = t_rx_mode'($urandom_range(0, 3));
                rx_mode_left = $urandom_range(32, 256);
            end else begin
                rx_mode_left--;
            end
            rx_tick++;
            if (hold_off_left != 0) begin
                i_out_stall <= 1'b1;
            end else begin
                case (rx_mode)
                    RX_LIGHT:    i_out_stall <= ($urandom_range(0, 3) == 0);
                    RX_HEAVY:    i_out_stall <= ($urandom_range(0, 9) < 7);
                    RX_PERIODIC: i_out_stall <= ((rx_tick % 8) < 3);
                    default:     i_out_stall <= 1'b0;
                endcase
            end
        end
    end

    // long hold-off while pixels are still queued, so the block backs up; rare random hold-offs besides
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_off_left <= 0;
        end else if (hold_off_left != 0) begin
            hold_off_left <= hold_off_left - 1;
        end else if (!long_hold_done && pixel_queue.size() > 40) begin
            hold_off_left  <= LONG_HOLD;
            long_hold_done <= 1'b1;
        end else if ($urandom_range(0, 2999) == 0) begin
            hold_off_left <= $urandom_range(60, 200);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic push_pixel(input logic [sem_pkg::PIX_W-1:0] pix);
        pixel_queue.push_back(pix);
        pixels_pushed++;
    endtask

    function automatic logic [sem_pkg::PIX_W-1:0] make_pixel(input t_pix_style style);
        case (style)
            PIX_EXTREME: return ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
            PIX_SMOOTH: begin
                smooth_base = smooth_base + int'($urandom_range(0, 8)) - 4;
                if (smooth_base < 0) smooth_base = 0;
                if (smooth_base > sem_pkg::PIX_MAX) smooth_base = sem_pkg::PIX_MAX;
                return sem_pkg::PIX_W'(smooth_base);
            end
            default: return sem_pkg::PIX_W'($urandom);
        endcase
    endfunction

    task automatic push_pixels(input int count, input t_pix_style style);
        for (int i = 0; i < count; i++) push_pixel(make_pixel(style));
    endtask

    // all pixels taken, all results in, then a settling wait for a border pixel
    task automatic wait_idle();
        int waited;
        waited = 0;
        while (pixels_accepted != pixels_pushed) @(posedge i_clk);
        while (edge_expect_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (edge_expect_q.size() != 0) begin
            fail_count++;
            $error("%0d expected edge results never arrived", edge_expect_q.size());
            edge_expect_q.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_frame_reg(input logic [sem_pkg::CFG_IDX_W-1:0] index,
                                   input logic [sem_pkg::CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        cfg_writes++;
        if (index == sem_pkg::REG_IMAGE_WIDTH) begin
            width_reg = data[sem_pkg::WIDTH_REG_W-1:0];
            next_col  = 0;
            next_row  = 0;
        end else if (index == sem_pkg::REG_IMAGE_HEIGHT) begin
            height_reg = data[sem_pkg::HEIGHT_REG_W-1:0];
            next_col   = 0;
            next_row   = 0;
        end
        @(posedge i_clk);
    endtask

    task automatic run_random_frames(output int count);
        logic [sem_pkg::CFG_DATA_W-1:0] wdata;
        logic [sem_pkg::CFG_DATA_W-1:0] hdata;
        int unsigned                    area;
        t_pix_style                     style;
        case ($urandom_range(0, 7))
            0:       wdata = sem_pkg::CFG_DATA_W'($urandom_range(0, 2));
            // bit 12 falls outside the width register
            1:       wdata = 13'h1000 | 13'($urandom_range(3, 12));
            default: wdata = sem_pkg::CFG_DATA_W'($urandom_range(3, 12));
        endcase
        if ($urandom_range(0, 7) == 0) hdata = sem_pkg::CFG_DATA_W'($urandom_range(0, 2));
        else hdata = sem_pkg::CFG_DATA_W'($urandom_range(3, 7));
        if ($urandom_range(0, 4) == 0)
            write_frame_reg(sem_pkg::CFG_IDX_W'($urandom_range(2, 255)),
                            sem_pkg::CFG_DATA_W'($urandom));
        case ($urandom_range(0, 3))
            0: write_frame_reg(sem_pkg::REG_IMAGE_WIDTH, wdata);
            1: write_frame_reg(sem_pkg::REG_IMAGE_HEIGHT, hdata);
            default: begin
                write_frame_reg(sem_pkg::REG_IMAGE_WIDTH, wdata);
                write_frame_reg(sem_pkg::REG_IMAGE_HEIGHT, hdata);
            end
        endcase
        area = effective_size(32'(width_reg), MAX_WIDTH) *
               effective_size(32'(height_reg), MAX_HEIGHT);
        // whole frames most of the time, else a cut frame that the next write restarts
        if ($urandom_range(0, 2) == 0) count = $urandom_range(1, 2 * area);
        else count = area * $urandom_range(1, 3);
        if (count > 150) count = $urandom_range(20, 150);
        style = t_pix_style'($urandom_range(0, 2));
        smooth_base = $urandom_range(0, sem_pkg::PIX_MAX);
        push_pixels(count, style);
        wait_idle();
    endtask

    // the widest frame only gets a partial first row
    task automatic run_largest_frames();
        write_frame_reg(sem_pkg::REG_IMAGE_WIDTH, 13'd4095);
        write_frame_reg(sem_pkg::REG_IMAGE_HEIGHT, 13'd3);
        push_pixels(40, PIX_NOISE);
        wait_idle();
        write_frame_reg(sem_pkg::REG_IMAGE_WIDTH, 13'd3);
        write_frame_reg(sem_pkg::REG_IMAGE_HEIGHT, 13'h1FFF);
        push_pixels(30, PIX_SMOOTH);
        wait_idle();
        write_frame_reg(sem_pkg::REG_IMAGE_HEIGHT, 13'd4);
    endtask

    initial begin
        logic [sem_pkg::PIX_W-1:0] strong_edge [9];
        logic [sem_pkg::PIX_W-1:0] weak_edge   [9];
        logic [sem_pkg::PIX_W-1:0] split_head  [4];
        logic [sem_pkg::PIX_W-1:0] split_tail  [7];
        int                        random_count;
        int                        phase_count;
        logic                      largest_done;

        strong_edge = '{8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255};
        weak_edge   = '{8'd10, 8'd10, 8'd12, 8'd10, 8'd10, 8'd12, 8'd10, 8'd10, 8'd12};
        split_head  = '{8'd1, 8'd2, 8'd3, 8'd4};
        split_tail  = '{8'd5, 8'd6, 8'd9, 8'd128, 8'd254, 8'd17, 8'd33};
        for (int i = 0; i < MAX_WIDTH; i++) begin
            row_above_mem[i]  = '0;
            row_above2_mem[i] = '0;
        end
        for (int i = 0; i < 6; i++) window_q[i] = '0;
        next_col     = 0;
        next_row     = 0;
        width_reg    = 12'd640;
        height_reg   = 13'd480;
        random_count = 0;
        largest_done = 1'b0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // sizes below the minimum act as 3x3
        write_frame_reg(sem_pkg::REG_IMAGE_WIDTH, 13'd0);
        write_frame_reg(sem_pkg::REG_IMAGE_HEIGHT, 13'd2);
        // full-swing vertical edge saturates to 0, then a faint one after the wrap
        foreach (strong_edge[i]) push_pixel(strong_edge[i]);
        foreach (weak_edge[i]) push_pixel(weak_edge[i]);
        foreach (split_head[i]) push_pixel(split_head[i]);
        wait_idle();
        // unknown index must not restart the frame
        write_frame_reg(BAD_REG_INDEX, 13'h1FFF);
        foreach (split_tail[i]) push_pixel(split_tail[i]);
        wait_idle();

        // deep queue of 3x3 frames, the long hold-off starts here
        push_pixels(PRESSURE_PIXELS, PIX_NOISE);
        wait_idle();

        // random part; the first size write restarts the frame cut above
        while (random_count < RANDOM_PIXELS) begin
            run_random_frames(phase_count);
            random_count += phase_count;
            if (!largest_done && random_count >= RANDOM_PIXELS / 2) begin
                run_largest_frames();
                largest_done = 1'b1;
            end
        end
        wait_idle();

        $display("covered %0d pixels and %0d edge results, %0d of them ending a frame",
                 pixels_accepted, results_seen, frame_ends);
        $display("%0d register writes, frame widths from 3 up to %0d, heights up to %0d",
                 cfg_writes, MAX_WIDTH, MAX_HEIGHT);
        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/sem_pkg.sv
rtl/sem_ram.sv
rtl/sem_isqrt.sv
rtl/sobel_edge_magnitude_3x3.sv
tb/tb_sobel_edge_magnitude_3x3.sv
